// ===== rtl/btb_pkg.sv =====
`timescale 1ns / 1ps

package btb_pkg;

   localparam int INDEX_BITS_DEFAULT   = 12;
   localparam int COUNTER_BITS_DEFAULT = 2;
   localparam int ADDRESS_BITS         = 32;

   localparam logic [1:0] MODE_PREDICT   = 2'd0;
   localparam logic [1:0] MODE_TAKEN     = 2'd1;
   localparam logic [1:0] MODE_NOT_TAKEN = 2'd2;

   typedef struct packed {
      logic load_req;
      logic clear_write;
      logic load_rsp;
      logic write_entry;
   } btb_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic is_predict;
      logic is_resolve;
   } btb_status_type;

endpackage

// ===== rtl/btb_ctrl.sv =====
`timescale 1ns / 1ps

module btb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  btb_pkg::btb_status_type status,
   output btb_pkg::btb_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      rsp_free;

   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      cmd.clear_write = (state_ff == ST_CLEAR);
      cmd.load_req    = (state_ff == ST_IDLE) && req_valid;
      cmd.load_rsp    = (state_ff == ST_LOOKUP) && status.is_predict && rsp_free;
      cmd.write_entry = (state_ff == ST_LOOKUP) && status.is_resolve;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_CLEAR: begin
               if (status.clear_done) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               if (status.is_predict) begin
                  if (rsp_free) begin
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
      end
   end

endmodule

// ===== rtl/btb_datapath.sv =====
`timescale 1ns / 1ps

module btb_datapath #(
   parameter int INDEX_BITS   = btb_pkg::INDEX_BITS_DEFAULT,
   parameter int COUNTER_BITS = btb_pkg::COUNTER_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  btb_pkg::btb_cmd_type              cmd,
   output btb_pkg::btb_status_type           status,
   input  logic [1:0]                        req_mode,
   input  logic [btb_pkg::ADDRESS_BITS-1:0]  req_pc,
   input  logic [btb_pkg::ADDRESS_BITS-1:0]  req_branch_target,
   input  logic                              req_delay_slot,
   output logic                              rsp_predict_taken,
   output logic                              rsp_predict_delayed,
   output logic [btb_pkg::ADDRESS_BITS-1:0]  rsp_predict_target
);

   localparam int ADDR_BITS  = btb_pkg::ADDRESS_BITS;
   localparam int TAG_BITS   = ADDR_BITS - INDEX_BITS;
   localparam int ENTRY_BITS = TAG_BITS + COUNTER_BITS + 1 + ADDR_BITS;
   localparam int DEPTH      = 1 << INDEX_BITS;
   localparam int TGT_LO     = 0;
   localparam int FLAG_POS   = ADDR_BITS;
   localparam int CTR_LO     = ADDR_BITS + 1;
   localparam int TAG_LO     = ADDR_BITS + 1 + COUNTER_BITS;

   localparam logic [COUNTER_BITS-1:0] CTR_MAX   = '1;
   localparam logic [COUNTER_BITS-1:0] CTR_RESET = CTR_MAX >> 1;
   localparam logic [INDEX_BITS-1:0]   IDX_LAST  = '1;

   logic [ENTRY_BITS-1:0] mem [DEPTH];

   logic [INDEX_BITS-1:0] clr_ff;
   logic [1:0]            mode_ff;
   logic [ADDR_BITS-1:0]  pc_ff;
   logic [ADDR_BITS-1:0]  target_ff;
   logic                  flag_ff;
   logic [ENTRY_BITS-1:0] rd_ff;
   logic                  taken_ff;
   logic                  delayed_ff;
   logic [ADDR_BITS-1:0]  out_target_ff;

   logic [INDEX_BITS-1:0]   rd_addr;
   logic [INDEX_BITS-1:0]   wr_addr;
   logic [ENTRY_BITS-1:0]   wr_data;
   logic [TAG_BITS-1:0]     rd_tag;
   logic [COUNTER_BITS-1:0] rd_ctr;
   logic [COUNTER_BITS-1:0] ctr_in;
   logic                    hit;

   assign status.clear_done = (clr_ff == IDX_LAST);
   assign status.is_predict = (mode_ff == btb_pkg::MODE_PREDICT);
   assign status.is_resolve = (mode_ff == btb_pkg::MODE_TAKEN)
                           || (mode_ff == btb_pkg::MODE_NOT_TAKEN);

   assign rd_addr = cmd.load_req ? req_pc[INDEX_BITS-1:0] : pc_ff[INDEX_BITS-1:0];
   assign rd_tag  = rd_ff[TAG_LO +: TAG_BITS];
   assign rd_ctr  = rd_ff[CTR_LO +: COUNTER_BITS];
   assign hit     = (rd_tag == pc_ff[ADDR_BITS-1:INDEX_BITS]);

   always_comb begin
      ctr_in = rd_ctr;
      if (mode_ff == btb_pkg::MODE_TAKEN) begin
         if (rd_ctr != CTR_MAX) begin
            ctr_in = rd_ctr + 1'b1;
         end
      end else begin
         if (rd_ctr != '0) begin
            ctr_in = rd_ctr - 1'b1;
         end
      end
   end

   always_comb begin
      if (cmd.clear_write) begin
         wr_addr = clr_ff;
         wr_data = {{TAG_BITS{1'b0}}, CTR_RESET, 1'b0, {ADDR_BITS{1'b0}}};
      end else begin
         wr_addr = pc_ff[INDEX_BITS-1:0];
         wr_data = {pc_ff[ADDR_BITS-1:INDEX_BITS], ctr_in, flag_ff, target_ff};
      end
   end

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (cmd.clear_write || cmd.write_entry) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         mode_ff <= btb_pkg::MODE_PREDICT;
      end else begin
         if (cmd.clear_write) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.load_req) begin
            mode_ff <= req_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         pc_ff     <= req_pc;
         target_ff <= req_branch_target;
         flag_ff   <= req_delay_slot;
      end
      if (cmd.load_rsp) begin
         taken_ff      <= hit && rd_ctr[COUNTER_BITS-1];
         delayed_ff    <= hit && rd_ff[FLAG_POS];
         out_target_ff <= hit ? rd_ff[TGT_LO +: ADDR_BITS] : '0;
      end
   end

   assign rsp_predict_taken   = taken_ff;
   assign rsp_predict_delayed = delayed_ff;
   assign rsp_predict_target  = out_target_ff;

endmodule

// ===== rtl/branch_target_buffer.sv =====
`timescale 1ns / 1ps
// a predict item's entry is read into rd_ff in the cycle that accepts it; its result
// is registered in the output registers, raising rsp_valid, when it leaves ST_LOOKUP
// a new item is accepted only in ST_IDLE, once the last one has left ST_LOOKUP, where
// its entry is used or written back; a predict item waits there while a result is held
// reset: a clearing pass writes all 2**INDEX_BITS entries (4096 by
// default); no item is accepted until it has finished
module branch_target_buffer #(
   parameter int INDEX_BITS   = btb_pkg::INDEX_BITS_DEFAULT,
   parameter int COUNTER_BITS = btb_pkg::COUNTER_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_mode,
   input  logic [btb_pkg::ADDRESS_BITS-1:0]  req_pc,
   input  logic [btb_pkg::ADDRESS_BITS-1:0]  req_branch_target,
   input  logic                              req_delay_slot,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_predict_taken,
   output logic                              rsp_predict_delayed,
   output logic [btb_pkg::ADDRESS_BITS-1:0]  rsp_predict_target
);

   btb_pkg::btb_cmd_type    cmd;
   btb_pkg::btb_status_type status;

   btb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   btb_datapath #(
      .INDEX_BITS   (INDEX_BITS),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_mode            (req_mode),
      .req_pc              (req_pc),
      .req_branch_target   (req_branch_target),
      .req_delay_slot      (req_delay_slot),
      .rsp_predict_taken   (rsp_predict_taken),
      .rsp_predict_delayed (rsp_predict_delayed),
      .rsp_predict_target  (rsp_predict_target)
   );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

localparam int SLOT_BITS = btb_pkg::INDEX_BITS_DEFAULT;
localparam int TAG_BITS = btb_pkg::ADDRESS_BITS - SLOT_BITS;
localparam int SLOT_COUNT = 1 << SLOT_BITS;
localparam logic [btb_pkg::COUNTER_BITS_DEFAULT-1:0] CTR_MAX = '1;
localparam logic [btb_pkg::COUNTER_BITS_DEFAULT-1:0] CTR_INIT = CTR_MAX >> 1;
localparam logic [btb_pkg::COUNTER_BITS_DEFAULT-1:0] CTR_TAKEN = CTR_INIT + 1'b1;
localparam logic [1:0] MODE_IGNORED = 2'd3;

typedef struct packed {
   logic                             taken;
   logic                             delayed;
   logic [btb_pkg::ADDRESS_BITS-1:0] target;
} btb_lookup_type;

class btb_mirror;
   logic [TAG_BITS-1:0]                         tags[SLOT_COUNT];
   logic [btb_pkg::COUNTER_BITS_DEFAULT-1:0]    counters[SLOT_COUNT];
   logic                                        flags[SLOT_COUNT];
   logic [btb_pkg::ADDRESS_BITS-1:0]            targets[SLOT_COUNT];
   btb_lookup_type                              pending_lookups[$];
   int unsigned                                 errors;

   function new();
      errors = 0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         tags[i] = '0;
         counters[i] = CTR_INIT;
         flags[i] = 1'b0;
         targets[i] = '0;
      end
   endfunction

   function void record_request(input logic [1:0] mode,
                                input logic [btb_pkg::ADDRESS_BITS-1:0] pc,
                                input logic [btb_pkg::ADDRESS_BITS-1:0] dest,
                                input logic slot_flag);
      logic [SLOT_BITS-1:0] slot;
      logic [TAG_BITS-1:0]  tag;
      btb_lookup_type       guess;
      slot = pc[SLOT_BITS-1:0];
      tag = pc[btb_pkg::ADDRESS_BITS-1:SLOT_BITS];
      case (mode)
         btb_pkg::MODE_PREDICT: begin
            if (tags[slot] != tag) begin
               guess = '0;
            end else begin
               guess.taken = (counters[slot] >= CTR_TAKEN);
               guess.delayed = flags[slot];
               guess.target = targets[slot];
            end
            pending_lookups.push_back(guess);
         end
         btb_pkg::MODE_TAKEN, btb_pkg::MODE_NOT_TAKEN: begin
            tags[slot] = tag;
            targets[slot] = dest;
            flags[slot] = slot_flag;
            if (mode == btb_pkg::MODE_TAKEN) begin
               if (counters[slot] != CTR_MAX) counters[slot] = counters[slot] + 1'b1;
            end else begin
               if (counters[slot] != '0) counters[slot] = counters[slot] - 1'b1;
            end
         end
         default: begin
         end
      endcase
   endfunction

   function void note_error(input string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
   endfunction

   function void check_lookup(input logic taken, input logic delayed,
                              input logic [btb_pkg::ADDRESS_BITS-1:0] target);
      btb_lookup_type want;
      if (pending_lookups.size() == 0) begin
         note_error($sformatf("unexpected item taken=%b delayed=%b target=%h",
                              taken, delayed, target));
         return;
      end
      want = pending_lookups.pop_front();
      if (taken !== want.taken)
         note_error($sformatf("predict_taken expected %b got %b", want.taken, taken));
      if (delayed !== want.delayed)
         note_error($sformatf("predict_delayed expected %b got %b", want.delayed, delayed));
      if (target !== want.target)
         note_error($sformatf("predict_target expected %h got %h", want.target, target));
   endfunction

   function int unsigned outstanding();
      return pending_lookups.size();
   endfunction
endclass

module tb_top;
   localparam int STALL_LIMIT = 20000;
   localparam int ITEMS_PER_PHASE = 452;

   logic                             clock;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [1:0]                       req_mode = btb_pkg::MODE_PREDICT;
   logic [btb_pkg::ADDRESS_BITS-1:0] req_pc = '0;
   logic [btb_pkg::ADDRESS_BITS-1:0] req_branch_target = '0;
   logic                             req_delay_slot = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic                             rsp_predict_taken;
   logic                             rsp_predict_delayed;
   logic [btb_pkg::ADDRESS_BITS-1:0] rsp_predict_target;

   btb_mirror   board = new();
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          quiet_cycles = 0;
   logic [btb_pkg::ADDRESS_BITS-1:0] hot_pcs[16];

   branch_target_buffer u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_pc              (req_pc),
      .req_branch_target   (req_branch_target),
      .req_delay_slot      (req_delay_slot),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_predict_taken   (rsp_predict_taken),
      .rsp_predict_delayed (rsp_predict_delayed),
      .rsp_predict_target  (rsp_predict_target)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         board.check_lookup(rsp_predict_taken, rsp_predict_delayed, rsp_predict_target);
      if (!reset && req_valid && req_ready === 1'b1)
         board.record_request(req_mode, req_pc, req_branch_target, req_delay_slot);
      if ((!reset && req_valid && req_ready === 1'b1) ||
          (!reset && rsp_valid === 1'b1 && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL branch_target_buffer");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] mode,
                            input logic [btb_pkg::ADDRESS_BITS-1:0] pc,
                            input logic [btb_pkg::ADDRESS_BITS-1:0] dest,
                            input logic slot_flag);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_pc <= pc;
      req_branch_target <= dest;
      req_delay_slot <= slot_flag;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // hold the sender back until every lookup has come back
   task automatic drain_lookups();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
   endtask

   task automatic send_random(output bit counted);
      int                               pick;
      logic [1:0]                       mode;
      logic [btb_pkg::ADDRESS_BITS-1:0] pc;
      pick = $urandom_range(99);
      if (pick < 45) mode = btb_pkg::MODE_PREDICT;
      else if (pick < 70) mode = btb_pkg::MODE_TAKEN;
      else if (pick < 95) mode = btb_pkg::MODE_NOT_TAKEN;
      else mode = MODE_IGNORED;
      if ($urandom_range(99) < 85) pc = hot_pcs[$urandom_range(15)];
      else pc = $urandom;
      send_item(mode, pc, $urandom, 1'($urandom_range(1)));
      counted = (mode != MODE_IGNORED);
   endtask

   initial begin
      logic [SLOT_BITS-1:0] slot;
      bit                   counted;
      int                   sent;

      for (int k = 0; k < 16; k += 2) begin
         hot_pcs[k] = $urandom;
         slot = hot_pcs[k][SLOT_BITS-1:0];
         hot_pcs[k + 1] = {TAG_BITS'($urandom), slot};
      end
      hot_pcs[15][btb_pkg::ADDRESS_BITS-1:SLOT_BITS] = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: reset hits, misses, saturation, aliasing, ignored mode
      send_item(btb_pkg::MODE_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_item(btb_pkg::MODE_PREDICT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      send_item(btb_pkg::MODE_PREDICT, 32'h0000_0FFF, 32'hFFFF_FFFF, 1'b1);
      send_item(btb_pkg::MODE_TAKEN, 32'hFFFF_F123, 32'hFFFF_FFFF, 1'b1);
      send_item(btb_pkg::MODE_PREDICT, 32'hFFFF_F123, 32'h0000_0000, 1'b0);
      send_item(btb_pkg::MODE_TAKEN, 32'hFFFF_F123, 32'hFFFF_FFFF, 1'b1);
      send_item(btb_pkg::MODE_TAKEN, 32'hFFFF_F123, 32'hFFFF_FFFF, 1'b1);
      send_item(btb_pkg::MODE_PREDICT, 32'hFFFF_F123, 32'h0000_0000, 1'b0);
      send_item(btb_pkg::MODE_NOT_TAKEN, 32'hFFFF_F123, 32'h0000_0000, 1'b0);
      send_item(btb_pkg::MODE_NOT_TAKEN, 32'hFFFF_F123, 32'h0000_0000, 1'b0);
      send_item(btb_pkg::MODE_NOT_TAKEN, 32'hFFFF_F123, 32'h0000_0000, 1'b0);
      send_item(btb_pkg::MODE_NOT_TAKEN, 32'hFFFF_F123, 32'h0000_0000, 1'b0);
      send_item(btb_pkg::MODE_PREDICT, 32'hFFFF_F123, 32'hFFFF_FFFF, 1'b1);
      send_item(btb_pkg::MODE_PREDICT, 32'h1234_5123, 32'h0000_0000, 1'b0);
      send_item(btb_pkg::MODE_TAKEN, 32'h1234_5123, 32'h8000_0001, 1'b1);
      send_item(btb_pkg::MODE_PREDICT, 32'h1234_5123, 32'h0000_0000, 1'b0);
      send_item(btb_pkg::MODE_PREDICT, 32'hFFFF_F123, 32'h0000_0000, 1'b0);
      send_item(MODE_IGNORED, 32'h1234_5123, 32'h5555_5555, 1'b0);
      send_item(btb_pkg::MODE_PREDICT, 32'h1234_5123, 32'h0000_0000, 1'b0);
      send_item(btb_pkg::MODE_TAKEN, 32'hFFFF_FFFF, 32'h7FFF_FFFE, 1'b0);
      send_item(btb_pkg::MODE_PREDICT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
      send_item(btb_pkg::MODE_PREDICT, 32'h0000_0FFF, 32'h0000_0000, 1'b0);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 19;
               recv_idle_pct = 75;
            end
            1: begin
               send_idle_pct = 75;
               recv_idle_pct = 19;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            send_random(counted);
            if (counted) sent++;
            if (phase < 2 && sent == ITEMS_PER_PHASE / 2 && counted) drain_lookups();
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
      repeat (16) @(posedge clock);

      if (board.errors == 0 && board.outstanding() == 0) begin
         $display("PASS branch_target_buffer");
      end else begin
         $display("FAIL branch_target_buffer");
      end
      $finish;
   end
endmodule
